FILE: sv/dertbs_pkg.sv
// Shared types and constants for the DER certificate TBS/signature splitter.
// No dependencies; imported by der_cert_tbs_signature_splitter and its bench.
package dertbs_pkg;

    // Longest long-form length field accepted, in bytes
    localparam int unsigned MAX_LENGTH_BYTES = 4;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned SIZE_W = 32;
    localparam int unsigned REGION_W = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned RES_W = REGION_W + STATUS_W + 2 * SIZE_W;
    localparam int unsigned OUT_W = ((RES_W + 7) / 8) * 8;

    localparam logic [DATA_W-1:0] LONG_FORM_BIT = 8'h80;
    localparam logic [6:0] LEN_COUNT_MASK = 7'h7F;

    typedef logic [REGION_W-1:0] region_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam region_t REGION_OUTER_HDR = 3'd0;
    localparam region_t REGION_TBS = 3'd1;
    localparam region_t REGION_SIG_ALG = 3'd2;
    localparam region_t REGION_SIG_HDR = 3'd3;
    localparam region_t REGION_UNUSED_BITS = 3'd4;
    localparam region_t REGION_SIG_VALUE = 3'd5;
    localparam region_t REGION_EXTRA = 3'd6;
    localparam region_t REGION_TRAILING = 3'd7;

    localparam status_t STATUS_UNDECIDED = 2'd0;
    localparam status_t STATUS_ACCEPTED = 2'd1;
    localparam status_t STATUS_REJECTED = 2'd2;

endpackage

FILE: sv/der_cert_tbs_signature_splitter.sv
// Top level of the DER certificate TBS/signature splitter: input register,
// TLV parse step, result register. Depends on dertbs_pkg.
//
// Takes a DER encoded certificate one byte per request and returns one
// result per byte: the region the byte belongs to (outer header, TBS TLV,
// signature algorithm, signature header, unused-bits byte, signature value,
// extra inner bytes, trailing bytes), a status, and on the byte marked with
// tlast the final verdict together with the full TBS TLV size and the
// signature value size (unused-bits byte excluded). Lengths may be short
// form or long form with up to four bytes; tags are not checked. Once an
// element fails its bounds check the status stays rejected and all further
// bytes are labeled trailing until tlast, after which the parser starts
// over on a fresh certificate. Throughput is one byte per clock if the
// master side does not stall. A taken byte sits in the input register,
// is parsed combinationally from there, and its result is written into
// the result register, with the parse-state update, once that register
// is free. While the master side stalls, the result register holds, the
// input register takes one more byte and then tready drops, so up to two
// bytes sit in flight.
module der_cert_tbs_signature_splitter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] data_byte
    input  logic [dertbs_pkg::DATA_W-1:0]    s_axis_tdata,
    // last_byte
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] region, [4:3] status, [36:5] tbs_size, [68:37] signature_size,
    // [71:69] zero
    output logic [dertbs_pkg::OUT_W-1:0]     m_axis_tdata,
    // done_res
    output logic                             m_axis_tlast
);
    import dertbs_pkg::*;

    typedef enum logic [3:0] {
        PH_OTAG,
        PH_OLEN,
        PH_OLENX,
        PH_ITAG,
        PH_ILEN,
        PH_ILENX,
        PH_IVAL,
        PH_EXTRA,
        PH_TRAIL,
        PH_REJ
    } phase_t;

    // pipeline control
    logic in_valid_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic in_last_reg;
    logic out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic out_last_reg;
    logic out_free;
    logic advance;
    logic in_take;

    // parse state
    phase_t phase_reg, phase_next;
    logic [SIZE_W-1:0] length_accum_reg, length_accum_next;
    logic [2:0] length_left_reg, length_left_next;
    logic [2:0] header_count_reg, header_count_next;
    logic [SIZE_W-1:0] element_left_reg, element_left_next;
    logic [SIZE_W-1:0] outer_left_reg, outer_left_next;
    logic [1:0] element_index_reg, element_index_next;
    logic [SIZE_W-1:0] tbs_total_reg, tbs_total_next;
    logic [SIZE_W-1:0] sig_total_reg, sig_total_next;
    logic rejected_reg, rejected_next;

    region_t region;
    status_t status;
    logic [SIZE_W-1:0] tbs_out;
    logic [SIZE_W-1:0] sig_out;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign advance = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_take = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tlast = out_last_reg;

    // One parse step per byte. Header end, element finish and element start
    // are chained in that order, each possibly triggering the next.
    always_comb
    begin
        logic [DATA_W-1:0] b;
        logic [6:0] n;
        logic [SIZE_W-1:0] hdr_len;
        logic [SIZE_W-1:0] accum_shift;
        logic do_end_header;
        logic do_finish;
        logic do_start;
        logic do_reject;

        b = in_data_reg;
        n = b[6:0] & LEN_COUNT_MASK;
        hdr_len = '0;
        accum_shift = {length_accum_reg[SIZE_W-DATA_W-1:0], b};
        do_end_header = 1'b0;
        do_finish = 1'b0;
        do_start = 1'b0;
        do_reject = 1'b0;

        phase_next = phase_reg;
        length_accum_next = length_accum_reg;
        length_left_next = length_left_reg;
        header_count_next = header_count_reg;
        element_left_next = element_left_reg;
        outer_left_next = outer_left_reg;
        element_index_next = element_index_reg;
        tbs_total_next = tbs_total_reg;
        sig_total_next = sig_total_reg;
        rejected_next = rejected_reg;
        region = REGION_TRAILING;

        case (phase_reg)
            PH_OTAG:
            begin
                region = REGION_OUTER_HDR;
                phase_next = PH_OLEN;
            end
            PH_OLEN:
            begin
                region = REGION_OUTER_HDR;
                if ((b & LONG_FORM_BIT) == '0)
                begin
                    outer_left_next = SIZE_W'(b);
                    do_start = 1'b1;
                end
                else if (n > 7'(MAX_LENGTH_BYTES))
                begin
                    do_reject = 1'b1;
                end
                else if (n == '0)
                begin
                    outer_left_next = '0;
                    do_start = 1'b1;
                end
                else
                begin
                    length_left_next = n[2:0];
                    length_accum_next = '0;
                    phase_next = PH_OLENX;
                end
            end
            PH_OLENX:
            begin
                region = REGION_OUTER_HDR;
                length_accum_next = accum_shift;
                length_left_next = length_left_reg - 3'd1;
                if (length_left_next == '0)
                begin
                    outer_left_next = accum_shift;
                    do_start = 1'b1;
                end
            end
            PH_ITAG:
            begin
                region = region_t'({1'b0, element_index_reg}) + REGION_TBS;
                outer_left_next = outer_left_reg - 1'b1;
                header_count_next = 3'd1;
                phase_next = PH_ILEN;
            end
            PH_ILEN:
            begin
                region = region_t'({1'b0, element_index_reg}) + REGION_TBS;
                outer_left_next = outer_left_reg - 1'b1;
                header_count_next = 3'd2;
                if ((b & LONG_FORM_BIT) == '0)
                begin
                    hdr_len = SIZE_W'(b);
                    do_end_header = 1'b1;
                end
                else if (n > 7'(MAX_LENGTH_BYTES) || SIZE_W'(n) > outer_left_next)
                begin
                    do_reject = 1'b1;
                end
                else if (n == '0)
                begin
                    hdr_len = '0;
                    do_end_header = 1'b1;
                end
                else
                begin
                    length_left_next = n[2:0];
                    length_accum_next = '0;
                    phase_next = PH_ILENX;
                end
            end
            PH_ILENX:
            begin
                region = region_t'({1'b0, element_index_reg}) + REGION_TBS;
                outer_left_next = outer_left_reg - 1'b1;
                header_count_next = header_count_reg + 3'd1;
                length_accum_next = accum_shift;
                length_left_next = length_left_reg - 3'd1;
                if (length_left_next == '0)
                begin
                    hdr_len = accum_shift;
                    do_end_header = 1'b1;
                end
            end
            PH_IVAL:
            begin
                if (element_index_reg == 2'd2)
                    region = (element_left_reg == sig_total_reg + 1'b1) ?
                             REGION_UNUSED_BITS : REGION_SIG_VALUE;
                else
                    region = region_t'({1'b0, element_index_reg}) + REGION_TBS;
                outer_left_next = outer_left_reg - 1'b1;
                element_left_next = element_left_reg - 1'b1;
                if (element_left_next == '0)
                    do_finish = 1'b1;
            end
            PH_EXTRA:
            begin
                region = REGION_EXTRA;
                outer_left_next = outer_left_reg - 1'b1;
                if (outer_left_next == '0)
                    phase_next = PH_TRAIL;
            end
            default:
            begin
                region = REGION_TRAILING;
            end
        endcase

        // end of an inner header: bounds check, record sizes
        if (do_end_header)
        begin
            if (hdr_len > outer_left_next ||
                (element_index_reg == 2'd2 && hdr_len == '0))
            begin
                do_reject = 1'b1;
            end
            else
            begin
                element_left_next = hdr_len;
                if (element_index_reg == 2'd0)
                    tbs_total_next = SIZE_W'(header_count_next) + hdr_len;
                if (element_index_reg == 2'd2)
                    sig_total_next = hdr_len - 1'b1;
                if (hdr_len == '0)
                    do_finish = 1'b1;
                else
                    phase_next = PH_IVAL;
            end
        end

        // element complete: move to the next one or past the third
        if (do_finish)
        begin
            element_index_next = element_index_reg + 2'd1;
            if (element_index_next == 2'd3)
                phase_next = (outer_left_next == '0) ? PH_TRAIL : PH_EXTRA;
            else
                do_start = 1'b1;
        end

        // new inner element needs at least tag and length bytes
        if (do_start)
        begin
            if (outer_left_next < SIZE_W'(2))
            begin
                do_reject = 1'b1;
            end
            else
            begin
                header_count_next = '0;
                phase_next = PH_ITAG;
            end
        end

        if (in_last_reg && phase_next != PH_TRAIL)
            do_reject = 1'b1;

        if (do_reject)
        begin
            rejected_next = 1'b1;
            phase_next = PH_REJ;
        end

        if (rejected_next)
            status = STATUS_REJECTED;
        else if (in_last_reg)
            status = STATUS_ACCEPTED;
        else
            status = STATUS_UNDECIDED;

        if (in_last_reg && !rejected_next)
        begin
            tbs_out = tbs_total_next;
            sig_out = sig_total_next;
        end
        else
        begin
            tbs_out = '0;
            sig_out = '0;
        end

        // certificate closed: start over
        if (in_last_reg)
        begin
            phase_next = PH_OTAG;
            length_accum_next = '0;
            length_left_next = '0;
            header_count_next = '0;
            element_left_next = '0;
            outer_left_next = '0;
            element_index_next = '0;
            tbs_total_next = '0;
            sig_total_next = '0;
            rejected_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg <= PH_OTAG;
            length_accum_reg <= '0;
            length_left_reg <= '0;
            header_count_reg <= '0;
            element_left_reg <= '0;
            outer_left_reg <= '0;
            element_index_reg <= '0;
            tbs_total_reg <= '0;
            sig_total_reg <= '0;
            rejected_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                phase_reg <= phase_next;
                length_accum_reg <= length_accum_next;
                length_left_reg <= length_left_next;
                header_count_reg <= header_count_next;
                element_left_reg <= element_left_next;
                outer_left_reg <= outer_left_next;
                element_index_reg <= element_index_next;
                tbs_total_reg <= tbs_total_next;
                sig_total_reg <= sig_total_next;
                rejected_reg <= rejected_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            out_data_reg <= OUT_W'({sig_out, tbs_out, status, region});
            out_last_reg <= in_last_reg;
        end
    end

endmodule

FILE: test/der_cert_tbs_signature_splitter_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for der_cert_tbs_signature_splitter: random DER certificates, good and
// damaged, stream in byte by byte; an in-bench parser predicts every result request.
// Depends on dertbs_pkg and the splitter RTL only.
module der_cert_tbs_signature_splitter_tb;
    import dertbs_pkg::*;

    // ---------------------------------------------------------------- types
    // One input request as the driver sees it. hold makes the driver wait for
    // the output side to drain before offering it; burst suppresses idle gaps.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hold;
        logic       burst;
    } cert_byte_t;

    // Predicted label and verdict for one byte
    typedef struct packed {
        region_t     region;
        status_t     status;
        logic        done;
        logic [31:0] tbs_size;
        logic [31:0] sig_size;
    } byte_label_t;

    typedef enum logic [3:0] {
        PH_OUTER_TAG,
        PH_OUTER_LEN,
        PH_OUTER_LEN_EXT,
        PH_INNER_TAG,
        PH_INNER_LEN,
        PH_INNER_LEN_EXT,
        PH_INNER_VALUE,
        PH_EXTRA_BYTES,
        PH_TRAILING,
        PH_REJECTED
    } parse_phase_t;

    // Ways a generated certificate can be damaged
    typedef enum logic [3:0] {
        FLAW_NONE,
        FLAW_SHORT_OUTER,   // outer length smaller than its content
        FLAW_LONG_OUTER,    // outer length larger than its content
        FLAW_HUGE_OUTER,    // four-byte outer length, never completed
        FLAW_TRUNCATED,     // tlast somewhere in the middle
        FLAW_CORRUPT,       // one byte overwritten
        FLAW_EMPTY_SIG,     // signature BIT STRING of length zero
        FLAW_WIDE_LENGTH,   // long-form count beyond the supported maximum
        FLAW_NOISE          // plain random bytes
    } cert_flaw_t;

    // ---------------------------------------------------------------- DUT
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata = '0;     // [7:0] data_byte
    logic                 s_axis_tlast = 1'b0;   // last_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [2:0] region, [4:3] status, [36:5] tbs_size, [68:37] signature_size
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 m_axis_tlast;          // done_res

    der_cert_tbs_signature_splitter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------- queues, counters
    cert_byte_t  cert_byte_q[$];    // requests waiting to be offered
    byte_label_t label_q[$];        // predicted results for accepted bytes
    logic [7:0]  cert_q[$];         // certificate under construction
    logic [7:0]  body_q[$];         // outer value, kept while the header is built

    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned bytes_sent = 0;
    int unsigned cert_count = 0;
    int unsigned certs_accepted = 0;
    int unsigned certs_rejected = 0;

    // ---------------------------------------------------------------- parser model
    // Mirror of the block's parse state, advanced once per accepted byte.
    parse_phase_t ph;
    logic [31:0]  len_acc;
    logic [2:0]   len_left;
    logic [2:0]   hdr_cnt;
    logic [32:0]  elem_left;
    logic [32:0]  outer_left;
    logic [1:0]   elem_idx;
    logic [31:0]  tbs_total;
    logic [31:0]  sig_total;
    logic         rejected;

    function void clear_parser();
        ph = PH_OUTER_TAG;
        len_acc = '0;
        len_left = '0;
        hdr_cnt = '0;
        elem_left = '0;
        outer_left = '0;
        elem_idx = '0;
        tbs_total = '0;
        sig_total = '0;
        rejected = 1'b0;
    endfunction

    function void mark_rejected();
        rejected = 1'b1;
        ph = PH_REJECTED;
    endfunction

    // A new inner element needs at least tag and length inside the outer value
    function void open_element();
        if (outer_left < 33'd2)
            mark_rejected();
        else
        begin
            hdr_cnt = '0;
            ph = PH_INNER_TAG;
        end
    endfunction

    function void close_element();
        elem_idx = elem_idx + 2'd1;
        if (elem_idx == 2'd3)
            ph = (outer_left == '0) ? PH_TRAILING : PH_EXTRA_BYTES;
        else
            open_element();
    endfunction

    // Length of the current element is known: bounds check, record sizes
    function void close_header(input logic [32:0] len);
        logic [32:0] sum;
        if (len > outer_left || (elem_idx == 2'd2 && len == '0))
            mark_rejected();
        else
        begin
            elem_left = len;
            if (elem_idx == 2'd0)
            begin
                sum = {30'd0, hdr_cnt} + len;
                tbs_total = sum[31:0];
            end
            if (elem_idx == 2'd2)
            begin
                sum = len - 33'd1;   // unused-bits byte is not counted
                sig_total = sum[31:0];
            end
            if (len == '0)
                close_element();
            else
                ph = PH_INNER_VALUE;
        end
    endfunction

    function byte_label_t parse_byte(input logic [7:0] b, input logic last);
        byte_label_t res;
        region_t     where;
        logic [6:0]  cnt;
        where = REGION_TRAILING;
        cnt = b[6:0] & LEN_COUNT_MASK;
        case (ph)
            PH_OUTER_TAG:
            begin
                where = REGION_OUTER_HDR;
                ph = PH_OUTER_LEN;
            end
            PH_OUTER_LEN:
            begin
                where = REGION_OUTER_HDR;
                if ((b & LONG_FORM_BIT) == '0)
                begin
                    outer_left = {25'd0, b};
                    open_element();
                end
                else if (cnt > MAX_LENGTH_BYTES)
                    mark_rejected();
                else if (cnt == '0)
                begin
                    outer_left = '0;
                    open_element();
                end
                else
                begin
                    len_left = cnt[2:0];
                    len_acc = '0;
                    ph = PH_OUTER_LEN_EXT;
                end
            end
            PH_OUTER_LEN_EXT:
            begin
                where = REGION_OUTER_HDR;
                len_acc = {len_acc[23:0], b};
                len_left = len_left - 3'd1;
                if (len_left == '0)
                begin
                    outer_left = {1'b0, len_acc};
                    open_element();
                end
            end
            PH_INNER_TAG:
            begin
                where = REGION_TBS + {1'b0, elem_idx};
                outer_left = outer_left - 33'd1;
                hdr_cnt = 3'd1;
                ph = PH_INNER_LEN;
            end
            PH_INNER_LEN:
            begin
                where = REGION_TBS + {1'b0, elem_idx};
                outer_left = outer_left - 33'd1;
                hdr_cnt = 3'd2;
                if ((b & LONG_FORM_BIT) == '0)
                    close_header({25'd0, b});
                else if (cnt > MAX_LENGTH_BYTES || {26'd0, cnt} > outer_left)
                    mark_rejected();
                else if (cnt == '0)
                    close_header('0);
                else
                begin
                    len_left = cnt[2:0];
                    len_acc = '0;
                    ph = PH_INNER_LEN_EXT;
                end
            end
            PH_INNER_LEN_EXT:
            begin
                where = REGION_TBS + {1'b0, elem_idx};
                outer_left = outer_left - 33'd1;
                hdr_cnt = hdr_cnt + 3'd1;
                len_acc = {len_acc[23:0], b};
                len_left = len_left - 3'd1;
                if (len_left == '0)
                    close_header({1'b0, len_acc});
            end
            PH_INNER_VALUE:
            begin
                if (elem_idx == 2'd2)
                    // first value byte of the BIT STRING is the unused-bits count
                    where = (elem_left == {1'b0, sig_total} + 33'd1) ?
                            REGION_UNUSED_BITS : REGION_SIG_VALUE;
                else
                    where = REGION_TBS + {1'b0, elem_idx};
                outer_left = outer_left - 33'd1;
                elem_left = elem_left - 33'd1;
                if (elem_left == '0)
                    close_element();
            end
            PH_EXTRA_BYTES:
            begin
                where = REGION_EXTRA;
                outer_left = outer_left - 33'd1;
                if (outer_left == '0)
                    ph = PH_TRAILING;
            end
            default:
                where = REGION_TRAILING;
        endcase

        // verdict on tlast: outer value and all three elements must be complete
        if (last && ph != PH_TRAILING)
            mark_rejected();

        res.region = where;
        res.status = rejected ? STATUS_REJECTED : (last ? STATUS_ACCEPTED : STATUS_UNDECIDED);
        res.done = last;
        res.tbs_size = (last && !rejected) ? tbs_total : '0;
        res.sig_size = (last && !rejected) ? sig_total : '0;
        if (last)
            clear_parser();
        return res;
    endfunction

    initial clear_parser();

    // ---------------------------------------------------------------- certificate builder
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // DER length: short form, 0x80 for zero, or long form with 1..4 bytes
    // (leading zero bytes allowed, the block does not insist on minimal encoding)
    task automatic put_len(input int unsigned len);
        int unsigned nb;
        int unsigned n;
        int unsigned k;
        if (len < 128 && $urandom_range(0, 3) != 0)
            cert_q.push_back(8'(len));
        else if (len == 0 && $urandom_range(0, 1) == 1)
            cert_q.push_back(LONG_FORM_BIT);
        else
        begin
            nb = (len < 32'h100) ? 1 : (len < 32'h1_0000) ? 2 : (len < 32'h100_0000) ? 3 : 4;
            n = $urandom_range(nb, MAX_LENGTH_BYTES);
            cert_q.push_back(LONG_FORM_BIT | 8'(n));
            for (k = n; k > 0; k--)
                cert_q.push_back(8'(len >> (8 * (k - 1))));
        end
    endtask

    // Inner TLV with random tag and content; wide puts an oversized length count
    task automatic put_tlv(input int unsigned len, input logic wide);
        int unsigned k;
        cert_q.push_back(rand_byte());
        if (wide)
            cert_q.push_back(8'($urandom_range(MAX_LENGTH_BYTES + 1, 127)) | LONG_FORM_BIT);
        else
            put_len(len);
        for (k = 0; k < len; k++)
            cert_q.push_back(rand_byte());
    endtask

    // Turn cert_q into requests, tlast on its final byte
    task automatic push_cert(input logic burst, input logic hold);
        cert_byte_t req;
        int unsigned i;
        for (i = 0; i < cert_q.size(); i++)
        begin
            req.data = cert_q[i];
            req.last = (i == cert_q.size() - 1);
            req.hold = hold && (i == 0);
            req.burst = burst;
            cert_byte_q.push_back(req);
        end
        cert_count++;
    endtask

    task automatic build_random_cert(input int unsigned cert_no);
        cert_flaw_t  flaw;
        int unsigned roll;
        int unsigned lt;
        int unsigned la;
        int unsigned ls;
        int unsigned decl_len;
        int unsigned keep;
        roll = $urandom_range(0, 99);
        // mostly well-formed certificates, so the signature regions get exercised
        flaw = (roll < 55) ? FLAW_NONE :
               (roll < 63) ? FLAW_SHORT_OUTER :
               (roll < 68) ? FLAW_LONG_OUTER :
               (roll < 71) ? FLAW_HUGE_OUTER :
               (roll < 79) ? FLAW_TRUNCATED :
               (roll < 86) ? FLAW_CORRUPT :
               (roll < 90) ? FLAW_EMPTY_SIG :
               (roll < 95) ? FLAW_WIDE_LENGTH : FLAW_NOISE;

        // occasionally a TBS long enough to need a two-byte length
        lt = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 300) : $urandom_range(0, 24);
        la = $urandom_range(0, 10);
        ls = (flaw == FLAW_EMPTY_SIG) ? 0 : $urandom_range(1, 30);

        cert_q.delete();
        put_tlv(lt, 1'b0);
        put_tlv(la, flaw == FLAW_WIDE_LENGTH && $urandom_range(0, 1) == 1);
        put_tlv(ls, flaw == FLAW_WIDE_LENGTH && $urandom_range(0, 1) == 0);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) cert_q.push_back(rand_byte());   // extra inner bytes
        body_q = cert_q;

        case (flaw)
            FLAW_SHORT_OUTER: decl_len = $urandom_range(0, body_q.size() - 1);
            FLAW_LONG_OUTER:  decl_len = body_q.size() + $urandom_range(1, 3);
            FLAW_HUGE_OUTER:  decl_len = $urandom() | 32'h0100_0000;
            default:          decl_len = body_q.size();
        endcase

        cert_q.delete();
        cert_q.push_back(rand_byte());
        put_len(decl_len);
        foreach (body_q[k])
            cert_q.push_back(body_q[k]);
        if (flaw == FLAW_NONE && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) cert_q.push_back(rand_byte());   // trailing bytes

        case (flaw)
            FLAW_TRUNCATED:
            begin
                keep = $urandom_range(1, cert_q.size() - 1);
                repeat (cert_q.size() - keep) void'(cert_q.pop_back());
            end
            FLAW_CORRUPT:
                cert_q[$urandom_range(0, cert_q.size() - 1)] = rand_byte();
            FLAW_NOISE:
            begin
                cert_q.delete();
                repeat ($urandom_range(1, 12)) cert_q.push_back(rand_byte());
            end
            default: ;
        endcase

        push_cert($urandom_range(0, 4) == 0, cert_no % 8 == 0);
    endtask

    // ---------------------------------------------------------------- idle/stall lengths
    // Mostly none or short, now and then a long one
    function automatic int unsigned draw_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 80)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 80);
    endfunction

    // ---------------------------------------------------------------- driver
    cert_byte_t  cur_req = '0;
    logic        offer;
    int unsigned idle_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
            idle_left = 0;
        end
        else
        begin
            offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                // request taken: predict its result now, in acceptance order
                label_q.push_back(parse_byte(cur_req.data, cur_req.last));
                bytes_sent++;
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (idle_left != 0)
                    idle_left--;
                else if (cert_byte_q.size() != 0 &&
                         (!cert_byte_q[0].hold || label_q.size() == 0))
                begin
                    cur_req = cert_byte_q.pop_front();
                    offer = 1'b1;
                    idle_left = cur_req.burst ? 0 : draw_idle();
                end
            end
            s_axis_tvalid <= offer;
            s_axis_tdata <= cur_req.data;
            s_axis_tlast <= cur_req.last;
        end
    end

    // ---------------------------------------------------------------- monitor
    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("ERROR %0t result %0d: %s got 0x%0h expected 0x%0h",
                     $time, results_seen, what, got, want);
    endtask

    byte_label_t want;
    logic        ready_next;
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned roll_m;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            calm_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (label_q.size() == 0)
                    report("result with no byte outstanding", m_axis_tdata[31:0], '0);
                else
                begin
                    want = label_q.pop_front();
                    if (m_axis_tdata[2:0] !== want.region)
                        report("region", m_axis_tdata[2:0], want.region);
                    if (m_axis_tdata[4:3] !== want.status)
                        report("status", m_axis_tdata[4:3], want.status);
                    if (m_axis_tlast !== want.done)
                        report("done_res", m_axis_tlast, want.done);
                    if (m_axis_tdata[36:5] !== want.tbs_size)
                        report("tbs_size", m_axis_tdata[36:5], want.tbs_size);
                    if (m_axis_tdata[68:37] !== want.sig_size)
                        report("signature_size", m_axis_tdata[68:37], want.sig_size);
                end
                if (m_axis_tlast)
                begin
                    if (m_axis_tdata[4:3] == STATUS_ACCEPTED)
                        certs_accepted++;
                    else
                        certs_rejected++;
                end
            end

            // backpressure: random stalls, with stall-free stretches now and then
            if (calm_left != 0)
            begin
                calm_left--;
                ready_next = 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                ready_next = 1'b0;
            end
            else
            begin
                ready_next = 1'b1;
                roll_m = $urandom_range(0, 99);
                if (roll_m < 2)
                    calm_left = $urandom_range(50, 250);
                else if (roll_m < 30)
                    stall_left = draw_idle();
            end
            m_axis_tready <= ready_next;
        end
    end

    // ---------------------------------------------------------------- sequence
    initial
    begin
        int unsigned n;

        // directed: one-byte certificate, rejected
        cert_q = '{8'hFF};
        push_cert(1'b1, 1'b0);
        // smallest complete certificate: empty TBS, zero length in 0x80 form,
        // signature holding only its unused-bits byte, then one trailing byte
        cert_q = '{8'h30, 8'h07, 8'h04, 8'h00, 8'h05, LONG_FORM_BIT, 8'h03, 8'h01, 8'h00,
                   8'hFF};
        push_cert(1'b1, 1'b0);
        // empty signature BIT STRING is rejected
        cert_q = '{8'h30, 8'h06, 8'h02, 8'h00, 8'h05, 8'h00, 8'h03, 8'h00};
        push_cert(1'b0, 1'b0);
        // outer long-form count one past the maximum
        cert_q = '{8'h30, LONG_FORM_BIT | 8'(MAX_LENGTH_BYTES + 1), 8'h00};
        push_cert(1'b0, 1'b0);

        // random part; every eighth certificate starts only on a drained pipe
        n = 0;
        while (cert_byte_q.size() < 1100)
        begin
            build_random_cert(n);
            n++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // settled values only: look between edges
        while (cert_byte_q.size() != 0 || s_axis_tvalid || label_q.size() != 0)
            @(negedge clk);
        // two-stage pipe; anything arriving now is an unexpected result
        repeat (10) @(posedge clk);

        $display("Streamed %0d certificates (%0d bytes, %0d results checked):",
                 cert_count, bytes_sent, results_seen);
        $display("  %0d accepted, %0d rejected, %0d mismatches",
                 certs_accepted, certs_rejected, mismatches);
        if (mismatches == 0 && label_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial
    begin
        #15_000_000;
        $display("Timeout with %0d bytes queued and %0d results outstanding",
                 cert_byte_q.size(), label_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
